@@ hw/rtl/orle_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered record list engine package
// Shared types and codes for the record cells and the list controller.
// ----------------------------------------------------------------------------
package orle_pkg;

    // Operation codes carried in the command.
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    // Status codes reported with every result.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_BAD_POS   = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  position;
        logic [55:0] key_high;
        logic [55:0] key_low;
        logic [63:0] name_part0;
        logic [63:0] name_part1;
        logic [31:0] name_part2;
        logic [15:0] age;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  found_position;
        logic [55:0] out_key_high;
        logic [55:0] out_key_low;
        logic [63:0] out_name_part0;
        logic [63:0] out_name_part1;
        logic [31:0] out_name_part2;
        logic [15:0] out_age;
        logic [7:0]  list_length;
    } result_t;

    // One stored record.
    typedef struct packed {
        logic [55:0] key_high;
        logic [55:0] key_low;
        logic [63:0] name_part0;
        logic [63:0] name_part1;
        logic [31:0] name_part2;
        logic [15:0] age;
    } entry_t;

    // Broadcast command to the row of cells.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_AT,
        CELL_INSERT_AT,
        CELL_DELETE_AT,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

@@ hw/rtl/orle_cell.sv @@
// ----------------------------------------------------------------------------
// Ordered record list cell
// Holds one record of the list and takes its next value from the new
// record or from either neighbor, as the broadcast command selects.
// ----------------------------------------------------------------------------
module orle_cell
    import orle_pkg::*;
#(
    parameter int IDX_W = 7,
    parameter int IDX   = 0
)
(
    input  logic             clk,
    input  cell_op_t         op,
    input  logic [IDX_W-1:0] index,
    input  entry_t           new_entry,
    input  entry_t           lower,
    input  entry_t           upper,
    output entry_t           entry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            CELL_LOAD_AT:
            begin
                if (MY_IDX == index)
                begin
                    entry_next = new_entry;
                end
            end
            CELL_INSERT_AT:
            begin
                if (MY_IDX == index)
                begin
                    entry_next = new_entry;
                end
                else if (MY_IDX > index)
                begin
                    entry_next = lower;
                end
            end
            CELL_DELETE_AT:
            begin
                if (MY_IDX >= index)
                begin
                    entry_next = upper;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = upper;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hw/rtl/ordered_record_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Ordered record list engine
// Keeps an ordered list of records in a row of cells, one record per cell.
// ----------------------------------------------------------------------------
// Usage: drive cmd and pulse start while busy is low; that edge accepts the
// transaction. Exactly one result follows, shown on result for the single
// cycle in which done is high; the receiver cannot stall it.
// Append, insert and delete update the row directly; they, undefined opcodes
// and every rejected operation need no scan, so the result appears in the
// cycle after acceptance and the next command may be accepted in that cycle.
// A valid read and every find rotate the whole row past cell 0 once, one
// cell per cycle, while busy stays high; the result appears after the last
// rotation step. After a full turn every record is back in its own cell.
// Positions count from 1; list_length is the entry count after the
// transaction, in its low eight bits.
// Reset empties the list and returns the engine to idle. The record cells
// are not cleared: a cell is only read after it has been written.
// ----------------------------------------------------------------------------
module ordered_record_list_engine_unit
    import orle_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = $clog2(CAPACITY);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [TW-1:0] LAST_SCAN  = TW'(CAPACITY - 1);

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [TW-1:0] scan_reg;
    logic [TW-1:0] scan_next;
    logic          hit_reg;
    logic          hit_next;
    logic          done_reg;
    logic          done_next;
    logic          find_reg;
    logic          find_next;
    logic [TW-1:0] tgt_reg;
    logic [TW-1:0] tgt_next;
    logic [55:0]   key_high_reg;
    logic [55:0]   key_high_next;
    logic [55:0]   key_low_reg;
    logic [55:0]   key_low_next;
    entry_t        hit_entry_reg;
    entry_t        hit_entry_next;
    logic [TW-1:0] hit_pos_reg;
    logic [TW-1:0] hit_pos_next;
    result_t       result_reg;
    result_t       result_next;

    cell_op_t      cell_op;
    logic [TW-1:0] cell_idx;
    entry_t        new_entry;
    entry_t        row [CAPACITY];

    logic          accept;
    logic          full;
    logic          pos_ok;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] len_ext;
    logic [PW-1:0] fpos_ext;
    logic [TW-1:0] idx0;
    logic          starts_scan;
    logic          last_scan;
    logic          match;
    logic          got_hit;
    entry_t        out_entry;
    logic [TW-1:0] out_pos;

    assign accept  = start && !busy;
    assign busy    = (state_reg == ST_SCAN);
    assign full    = (count_reg == FULL_COUNT);
    assign pos_ext = PW'(cmd.position);
    assign cnt_ext = PW'(count_reg);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign idx0    = TW'(pos_ext - PW'(1));
    assign len_ext = PW'(count_next);

    assign starts_scan = ((cmd.op == OP_READ) && pos_ok) || (cmd.op == OP_FIND);
    assign last_scan   = (state_reg == ST_SCAN) && (scan_reg == LAST_SCAN);

    assign new_entry.key_high   = cmd.key_high;
    assign new_entry.key_low    = cmd.key_low;
    assign new_entry.name_part0 = cmd.name_part0;
    assign new_entry.name_part1 = cmd.name_part1;
    assign new_entry.name_part2 = cmd.name_part2;
    assign new_entry.age        = cmd.age;

    // Cell 0 holds the record at list index scan_reg during a rotation.
    always_comb
    begin
        if (find_reg)
        begin
            match = !hit_reg && (CW'(scan_reg) < count_reg)
                    && (row[0].key_high == key_high_reg)
                    && (row[0].key_low == key_low_reg);
        end
        else
        begin
            match = (scan_reg == tgt_reg);
        end
    end

    assign got_hit   = hit_reg || match;
    assign out_entry = match ? row[0] : hit_entry_reg;
    assign out_pos   = match ? scan_reg : hit_pos_reg;
    assign fpos_ext  = PW'(out_pos) + PW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && starts_scan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_scan)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_op        = CELL_HOLD;
        cell_idx       = '0;
        count_next     = count_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        done_next      = 1'b0;
        find_next      = find_reg;
        tgt_next       = tgt_reg;
        key_high_next  = key_high_reg;
        key_low_next   = key_low_reg;
        hit_entry_next = hit_entry_reg;
        hit_pos_next   = hit_pos_reg;
        result_next    = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next        = '0;
                    result_next.status = STATUS_OK;
                    done_next          = 1'b1;
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                cell_op    = CELL_LOAD_AT;
                                cell_idx   = TW'(count_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else if (!pos_ok)
                            begin
                                result_next.status = STATUS_BAD_POS;
                            end
                            else
                            begin
                                cell_op    = CELL_INSERT_AT;
                                cell_idx   = idx0;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!pos_ok)
                            begin
                                result_next.status = STATUS_BAD_POS;
                            end
                            else
                            begin
                                cell_op    = CELL_DELETE_AT;
                                cell_idx   = idx0;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_READ:
                        begin
                            if (!pos_ok)
                            begin
                                result_next.status = STATUS_BAD_POS;
                            end
                        end
                        default:
                        begin
                            result_next.status = STATUS_OK;
                        end
                    endcase
                    result_next.list_length = len_ext[7:0];
                    if (starts_scan)
                    begin
                        done_next     = 1'b0;
                        scan_next     = '0;
                        hit_next      = 1'b0;
                        find_next     = (cmd.op == OP_FIND);
                        tgt_next      = idx0;
                        key_high_next = cmd.key_high;
                        key_low_next  = cmd.key_low;
                    end
                end
            end
            ST_SCAN:
            begin
                cell_op   = CELL_ROTATE;
                scan_next = scan_reg + TW'(1);
                if (match)
                begin
                    hit_next       = 1'b1;
                    hit_entry_next = row[0];
                    hit_pos_next   = scan_reg;
                end
                if (last_scan)
                begin
                    done_next               = 1'b1;
                    result_next             = '0;
                    result_next.list_length = len_ext[7:0];
                    if (got_hit)
                    begin
                        result_next.status         = STATUS_OK;
                        result_next.found_position = fpos_ext[7:0];
                        result_next.out_key_high   = out_entry.key_high;
                        result_next.out_key_low    = out_entry.key_low;
                        result_next.out_name_part0 = out_entry.name_part0;
                        result_next.out_name_part1 = out_entry.name_part1;
                        result_next.out_name_part2 = out_entry.name_part2;
                        result_next.out_age        = out_entry.age;
                    end
                    else
                    begin
                        result_next.status = STATUS_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        find_reg      <= find_next;
        tgt_reg       <= tgt_next;
        key_high_reg  <= key_high_next;
        key_low_reg   <= key_low_next;
        hit_entry_reg <= hit_entry_next;
        hit_pos_reg   <= hit_pos_next;
        result_reg    <= result_next;
    end

    // The row is a ring: a rotation moves every record one cell toward cell 0.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        orle_cell #(
            .IDX_W (TW),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .op        (cell_op),
            .index     (cell_idx),
            .new_entry (new_entry),
            .lower     (row[(i + CAPACITY - 1) % CAPACITY]),
            .upper     (row[(i + 1) % CAPACITY]),
            .entry     (row[i])
        );
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe raised while a scan is still running");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds the capacity");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op != OP_READ && cmd.op != OP_FIND) |=> done)
        else $error("single-edge transaction produced no result");

    a_scan_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("entry count changed during a rotation");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Ordered record list engine testbench
// Drives list commands through the start/busy handshake in random bursts,
// tracks the expected list contents in a shadow copy, and compares every
// strobed result field by field against the predicted one.
// ----------------------------------------------------------------------------
module tb_top;
    import orle_pkg::*;

    localparam int CAPACITY      = 128;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = CAPACITY + 20;
    localparam int POOL_SIZE     = 8;
    localparam int GROW_ITEMS    = 220;
    localparam int SHRINK_ITEMS  = 200;
    localparam int MIXED_ITEMS   = 180;
    localparam int MAX_POSITION  = 255;

    // Opcodes the block does not define; it must answer them with an empty result.
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    typedef enum int {
        SEG_GROW,
        SEG_SHRINK,
        SEG_MIXED
    } segment_t;

    typedef struct {
        cmd_t c;
        bit   drain;
    } pending_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;
    logic    timed_out;

    pending_t pending_q[$];
    result_t  expected_q[$];

    // Shadow copy of the list held by the block.
    entry_t list_rec[CAPACITY];
    int     list_len = 0;

    // Length the list will have once every queued command has run.
    int          gen_len = 0;
    logic [55:0] pool_hi[POOL_SIZE];
    logic [55:0] pool_lo[POOL_SIZE];

    int burst_left   = 0;
    int gap_left     = 0;
    int error_count  = 0;
    int result_count = 0;
    int idle_cycles  = 0;

    ordered_record_list_engine_unit #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR: result %0d: %s: got %0h, expected %0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Applies one command to the shadow list and returns the result it produces.
    function automatic result_t predict_list_op(cmd_t c);
        result_t r;
        entry_t  rec;
        int      pos;
        int      hit;
        int      i;
        r   = '0;
        pos = c.position;
        hit = -1;
        rec = {c.key_high, c.key_low, c.name_part0, c.name_part1, c.name_part2, c.age};
        r.status = STATUS_OK;
        case (c.op)
            OP_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = STATUS_FULL;
                else
                begin
                    list_rec[list_len] = rec;
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                // The full check takes priority over the position check.
                if (list_len >= CAPACITY)
                    r.status = STATUS_FULL;
                else if (pos < 1 || pos > list_len)
                    r.status = STATUS_BAD_POS;
                else
                begin
                    for (i = list_len; i >= pos; i--)
                        list_rec[i] = list_rec[i - 1];
                    list_rec[pos - 1] = rec;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    r.status = STATUS_BAD_POS;
                else
                begin
                    for (i = pos - 1; i < list_len - 1; i++)
                        list_rec[i] = list_rec[i + 1];
                    list_len--;
                end
            end
            OP_READ:
            begin
                if (pos < 1 || pos > list_len)
                    r.status = STATUS_BAD_POS;
                else
                    hit = pos - 1;
            end
            OP_FIND:
            begin
                r.status = STATUS_NOT_FOUND;
                for (i = 0; i < list_len && hit < 0; i++)
                    if (list_rec[i].key_high == c.key_high && list_rec[i].key_low == c.key_low)
                        hit = i;
                if (hit >= 0)
                    r.status = STATUS_OK;
            end
            default:
            begin
            end
        endcase
        if (hit >= 0)
        begin
            r.found_position = 8'(hit + 1);
            r.out_key_high   = list_rec[hit].key_high;
            r.out_key_low    = list_rec[hit].key_low;
            r.out_name_part0 = list_rec[hit].name_part0;
            r.out_name_part1 = list_rec[hit].name_part1;
            r.out_name_part2 = list_rec[hit].name_part2;
            r.out_age        = list_rec[hit].age;
        end
        r.list_length = 8'(list_len);
        return r;
    endfunction

    function automatic cmd_t random_cmd(logic [2:0] op, int pos);
        cmd_t c;
        int   k;
        c.op       = op;
        c.position = 8'(pos);
        k = $urandom_range(0, POOL_SIZE - 1);
        // Most keys come from a small pool so that searches hit and duplicates occur.
        if ($urandom_range(0, 4) == 0)
        begin
            c.key_high = 56'({$urandom, $urandom});
            c.key_low  = 56'({$urandom, $urandom});
        end
        else
        begin
            c.key_high = pool_hi[k];
            c.key_low  = pool_lo[k];
        end
        c.name_part0 = {$urandom, $urandom};
        c.name_part1 = {$urandom, $urandom};
        c.name_part2 = $urandom;
        c.age        = 16'($urandom);
        return c;
    endfunction

    function automatic void queue_command(cmd_t c, bit drain);
        pending_t p;
        case (c.op)
            OP_APPEND:
                if (gen_len < CAPACITY)
                    gen_len++;
            OP_INSERT:
                if (gen_len < CAPACITY && c.position >= 1 && c.position <= gen_len)
                    gen_len++;
            OP_DELETE:
                if (c.position >= 1 && c.position <= gen_len)
                    gen_len--;
            default:
            begin
            end
        endcase
        p.c     = c;
        p.drain = drain;
        pending_q.push_back(p);
    endfunction

    function automatic int pick_position(bit valid);
        int r;
        r = $urandom_range(0, 3);
        if (!valid || gen_len == 0)
        begin
            if (r == 0)
                return 0;
            else if (r == 1)
                return gen_len + 1;
            else
                return $urandom_range(gen_len + 1, MAX_POSITION);
        end
        if (r == 0)
            return 1;
        else if (r == 1)
            return gen_len;
        else
            return $urandom_range(1, gen_len);
    endfunction

    function automatic void add_random_item(segment_t seg, bit drain);
        int         roll;
        int         w_app;
        int         w_ins;
        int         w_del;
        int         w_rd;
        int         w_fd;
        logic [2:0] op;
        int         pos;
        case (seg)
            SEG_GROW:   begin w_app = 45; w_ins = 30; w_del = 5;  w_rd = 10; w_fd = 8;  end
            SEG_SHRINK: begin w_app = 10; w_ins = 8;  w_del = 55; w_rd = 12; w_fd = 12; end
            default:    begin w_app = 20; w_ins = 20; w_del = 20; w_rd = 18; w_fd = 18; end
        endcase
        roll = $urandom_range(0, 99);
        pos  = pick_position($urandom_range(0, 9) != 0);
        if (roll < w_app)
            op = OP_APPEND;
        else if (roll < w_app + w_ins)
            op = OP_INSERT;
        else if (roll < w_app + w_ins + w_del)
            op = OP_DELETE;
        else if (roll < w_app + w_ins + w_del + w_rd)
            op = OP_READ;
        else if (roll < w_app + w_ins + w_del + w_rd + w_fd)
            op = OP_FIND;
        else
        begin
            op  = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            pos = $urandom_range(0, MAX_POSITION);
        end
        queue_command(random_cmd(op, pos), drain || $urandom_range(0, 99) == 0);
    endfunction

    // Driver: one transaction per accepted start, sent in bursts with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        pending_t nxt;
        int       roll;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (start && !busy)
                expected_q.push_back(predict_list_op(cmd));
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_q.size() != 0
                         && !(pending_q[0].drain && expected_q.size() != 0))
                begin
                    nxt = pending_q.pop_front();
                    cmd   <= nxt.c;
                    start <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        // Long gaps reach across the whole scan of a read or find.
                        roll = $urandom_range(0, 99);
                        if (roll < 50)
                            gap_left = 0;
                        else if (roll < 85)
                            gap_left = $urandom_range(1, 4);
                        else
                            gap_left = $urandom_range(5, CAPACITY + 22);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (expected_q.size() == 0)
                report_mismatch("result with no transaction pending", result.status, '0);
            else
            begin
                want = expected_q.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.found_position !== want.found_position)
                    report_mismatch("found_position", result.found_position,
                                    want.found_position);
                if (result.out_key_high !== want.out_key_high)
                    report_mismatch("out_key_high", result.out_key_high, want.out_key_high);
                if (result.out_key_low !== want.out_key_low)
                    report_mismatch("out_key_low", result.out_key_low, want.out_key_low);
                if (result.out_name_part0 !== want.out_name_part0)
                    report_mismatch("out_name_part0", result.out_name_part0,
                                    want.out_name_part0);
                if (result.out_name_part1 !== want.out_name_part1)
                    report_mismatch("out_name_part1", result.out_name_part1,
                                    want.out_name_part1);
                if (result.out_name_part2 !== want.out_name_part2)
                    report_mismatch("out_name_part2", result.out_name_part2,
                                    want.out_name_part2);
                if (result.out_age !== want.out_age)
                    report_mismatch("out_age", result.out_age, want.out_age);
                if (result.list_length !== want.list_length)
                    report_mismatch("list_length", result.list_length, want.list_length);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles < STALL_LIMIT)
            idle_cycles <= idle_cycles + 1;
    end

    assign timed_out = (idle_cycles >= STALL_LIMIT);

    initial
    begin
        cmd_t c;
        int   k;
        for (k = 0; k < POOL_SIZE; k++)
        begin
            // The upper half of the pool shares key_high with the lower half.
            pool_hi[k] = (k < POOL_SIZE / 2) ? 56'({$urandom, $urandom})
                                             : pool_hi[k - POOL_SIZE / 2];
            pool_lo[k] = 56'({$urandom, $urandom});
        end

        // Empty list: every position is out of range and no key can match.
        queue_command(random_cmd(OP_READ, 1), 1'b0);
        queue_command(random_cmd(OP_DELETE, 1), 1'b0);
        queue_command(random_cmd(OP_INSERT, 1), 1'b0);
        queue_command(random_cmd(OP_FIND, 0), 1'b0);
        for (k = OP_RESERVED_LO; k <= OP_RESERVED_HI; k++)
            queue_command(random_cmd(3'(k), $urandom_range(0, MAX_POSITION)), 1'b0);

        c = '1;
        c.op = OP_APPEND;
        queue_command(c, 1'b0);
        c = '0;
        c.op = OP_APPEND;
        queue_command(c, 1'b0);
        c = random_cmd(OP_INSERT, 1);
        c.key_high = pool_hi[1];
        c.key_low  = pool_lo[1];
        queue_command(c, 1'b0);
        // Insert at the last position is legal, one past it is not.
        queue_command(random_cmd(OP_INSERT, 3), 1'b0);
        queue_command(random_cmd(OP_INSERT, 5), 1'b0);
        queue_command(random_cmd(OP_READ, 0), 1'b0);
        queue_command(random_cmd(OP_READ, MAX_POSITION), 1'b0);
        queue_command(random_cmd(OP_READ, 1), 1'b0);
        queue_command(random_cmd(OP_READ, 4), 1'b0);
        c = random_cmd(OP_FIND, 0);
        c.key_high = '1;
        c.key_low  = '1;
        queue_command(c, 1'b1);
        c.key_high = '0;
        c.key_low  = '0;
        queue_command(c, 1'b0);
        // A second record with the same key: the search must report the first one.
        c = random_cmd(OP_APPEND, 0);
        c.key_high = pool_hi[1];
        c.key_low  = pool_lo[1];
        queue_command(c, 1'b0);
        c.op = OP_FIND;
        queue_command(c, 1'b0);
        c.key_low = pool_lo[1 + POOL_SIZE / 2];
        queue_command(c, 1'b0);
        queue_command(random_cmd(OP_DELETE, 5), 1'b0);
        queue_command(random_cmd(OP_DELETE, 1), 1'b0);
        queue_command(random_cmd(OP_DELETE, 0), 1'b0);
        queue_command(random_cmd(OP_READ, 1), 1'b0);

        // Fill to capacity and push against it, drain most of it, then mix.
        for (k = 0; k < GROW_ITEMS; k++)
            add_random_item(SEG_GROW, k == 0);
        for (k = 0; k < SHRINK_ITEMS; k++)
            add_random_item(SEG_SHRINK, k == 0);
        for (k = 0; k < MIXED_ITEMS; k++)
            add_random_item(SEG_MIXED, k == 0);

        while (!timed_out && (pending_q.size() != 0 || start || expected_q.size() != 0))
            @(negedge clk);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge clk);

        if (timed_out)
            $display("Test completed with failures");
        else
        begin
            if (error_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ ordered_record_list_engine_unit.f @@
hw/rtl/orle_pkg.sv
hw/rtl/orle_cell.sv
hw/rtl/ordered_record_list_engine_unit.sv
tb/tb_top.sv
